FILE: rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation core.
`timescale 1ns / 1ps
package bsc_pkg;

   localparam int DATA_W    = 64;
   localparam int RAW_W     = 20;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_W     = 64;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] REG_S0_TEMP  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_S0_PLO   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_S0_PHI   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_S0_P9    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_S1_TEMP  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_S1_PLO   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_S1_PHI   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_S1_P9    = 4'd7;

   localparam logic CMD_TEMP  = 1'b0;
   localparam logic CMD_PRESS = 1'b1;

   localparam logic [63:0] FT_OFFSET  = 64'd128000;
   localparam logic [63:0] P_BASE     = 64'd1048576;
   localparam logic [63:0] P_SCALE    = 64'd3125;
   localparam logic [63:0] ONE_47     = 64'h0000_8000_0000_0000;
   localparam logic [31:0] T_ROUND    = 32'd128;

   typedef struct packed {
      logic             command;
      logic             sensor_select;
      logic [RAW_W-1:0] raw_reading;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               divide_by_zero;
   } rsp_type;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage

FILE: rtl/core/bsc_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, low product bits kept.
`timescale 1ns / 1ps
module bsc_mul import bsc_pkg::*; #(
   parameter int WIDTH = DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in, prod_ff, prod_in;

   assign done    = busy_ff && (b_ff == '0);
   assign product = prod_ff;

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = op_a;
         b_in    = op_b;
         prod_in = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) prod_in = prod_ff + a_ff;
            a_in = {a_ff[WIDTH-2:0], 1'b0};
            b_in = {1'b0, b_ff[WIDTH-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/core/bsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bsc_div import bsc_pkg::*; #(
   parameter int WIDTH = DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] numer,
   input  logic [WIDTH-1:0] denom,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [WIDTH:0]   shifted, diff;

   assign done     = busy_ff && (cnt_ff == LAST);
   assign quotient = quo_ff;
   assign shifted  = {rem_ff, quo_ff[WIDTH-1]};
   assign diff     = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (!diff[WIDTH]) begin
               rem_in = diff[WIDTH-1:0];
               quo_in = {quo_ff[WIDTH-2:0], 1'b1};
            end else begin
               rem_in = shifted[WIDTH-1:0];
               quo_in = {quo_ff[WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

FILE: rtl/core/baro_sensor_compensation_core.sv
// Top level of the barometric compensation core: sequencer, coefficients, result register.
`timescale 1ns / 1ps
// One word at a time. A temperature word runs three passes of the shared
// bit-serial multiplier; a pressure word runs ten multiplier passes and one
// divide. A multiplier pass shifts through its multiplier only up to the
// highest set bit. A zero divisor ends a pressure word after six passes.
// The next word is taken once the previous result has been loaded into the
// output register.
module baro_sensor_compensation_core import bsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam logic [3:0] S_T0  = 4'd0;
   localparam logic [3:0] S_T1  = 4'd1;
   localparam logic [3:0] S_T2  = 4'd2;
   localparam logic [3:0] S_P0  = 4'd3;
   localparam logic [3:0] S_P1  = 4'd4;
   localparam logic [3:0] S_P2  = 4'd5;
   localparam logic [3:0] S_P3  = 4'd6;
   localparam logic [3:0] S_P4  = 4'd7;
   localparam logic [3:0] S_P5  = 4'd8;
   localparam logic [3:0] S_P6  = 4'd9;
   localparam logic [3:0] S_DIV = 4'd10;
   localparam logic [3:0] S_P8  = 4'd11;
   localparam logic [3:0] S_P9  = 4'd12;
   localparam logic [3:0] S_P10 = 4'd13;

   logic [47:0] tc_ff [2];
   logic [63:0] plo_ff [2];
   logic [63:0] phi_ff [2];
   logic [15:0] p9_ff [2];

   logic [1:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic        cmd_ff, cmd_in, sel_ff, sel_in;
   logic [RAW_W-1:0] adc_ff, adc_in;
   logic [31:0] fine_ff, fine_in;
   logic [63:0] m1_ff, m1_in, m_ff, m_in, acc_ff, acc_in, v2_ff, v2_in;
   logic [63:0] d_ff, d_in, p_ff, p_in;
   logic        dz_ff, dz_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        mul_start, mul_done, div_start, div_done;
   logic [63:0] mul_a, mul_b, mul_prod, div_q;
   logic [63:0] nmag, dmag;

   logic [47:0] tc;
   logic [63:0] plo, phi;
   logic [63:0] t1, t2, t3, adc64, ta, tb;
   logic [63:0] ft64, v1, num0, a13, pres_sum, pres;
   logic [31:0] ft_w, cent;

   // coefficient views for the selected sensor
   assign tc    = tc_ff[sel_ff];
   assign plo   = plo_ff[sel_ff];
   assign phi   = phi_ff[sel_ff];
   assign t1    = {48'd0, tc[15:0]};
   assign t2    = sx16(tc[31:16]);
   assign t3    = sx16(tc[47:32]);
   assign adc64 = {{(64-RAW_W){1'b0}}, adc_ff};
   assign ta    = (adc64 >> 3) - {t1[62:0], 1'b0};
   assign tb    = (adc64 >> 4) - t1;

   assign ft64  = {{32{fine_ff[31]}}, fine_ff};
   assign v1    = ft64 - FT_OFFSET;
   assign num0  = ((P_BASE - adc64) << 31) - v2_ff;
   assign a13   = 64'($signed(p_ff) >>> 13);

   assign ft_w  = acc_ff[31:0] + 32'($signed(mul_prod[31:0]) >>> 14);
   assign cent  = 32'($signed({fine_ff[29:0], 2'b00} + fine_ff + T_ROUND) >>> 8);
   assign pres_sum = p_ff + acc_ff + v2_ff;
   assign pres  = 64'($signed(pres_sum) >>> 8) + (sx16(phi[47:32]) << 4);

   // sign-magnitude split for the divide
   assign nmag = m1_ff[63] ? (64'd0 - m1_ff) : m1_ff;
   assign dmag = d_ff[63]  ? (64'd0 - d_ff)  : d_ff;

   always_comb begin
      mul_a = v1;
      mul_b = v1;
      case (step_ff)
         S_T0:    begin mul_a = ta;    mul_b = t2; end
         S_T1:    begin mul_a = tb;    mul_b = tb; end
         S_T2:    begin mul_a = m_ff;  mul_b = t3; end
         S_P0:    begin mul_a = v1;    mul_b = v1; end
         S_P1:    begin mul_a = m1_ff; mul_b = sx16(phi[31:16]); end
         S_P2:    begin mul_a = v1;    mul_b = sx16(phi[15:0]); end
         S_P3:    begin mul_a = m1_ff; mul_b = sx16(plo[47:32]); end
         S_P4:    begin mul_a = v1;    mul_b = sx16(plo[31:16]); end
         S_P5:    begin mul_a = ONE_47 + acc_ff; mul_b = {48'd0, plo[15:0]}; end
         S_P6:    begin mul_a = num0;  mul_b = P_SCALE; end
         S_P8:    begin mul_a = sx16(p9_ff[sel_ff]); mul_b = a13; end
         S_P9:    begin mul_a = m_ff;  mul_b = a13; end
         S_P10:   begin mul_a = sx16(phi[63:48]); mul_b = p_ff; end
         default: begin mul_a = v1;    mul_b = v1; end
      endcase
   end

   assign mul_start = (state_ff == ST_ISSUE) && (step_ff != S_DIV);
   assign div_start = (state_ff == ST_ISSUE) && (step_ff == S_DIV);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      sel_in       = sel_ff;
      adc_in       = adc_ff;
      fine_in      = fine_ff;
      m1_in        = m1_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      v2_in        = v2_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               sel_in   = req_data.sensor_select;
               adc_in   = req_data.raw_reading;
               dz_in    = 1'b0;
               step_in  = (req_data.command == CMD_PRESS) ? S_P0 : S_T0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if ((step_ff == S_DIV) ? div_done : mul_done) begin
               state_in = ST_ISSUE;
               step_in  = step_ff + 4'd1;
               case (step_ff)
                  S_T0: acc_in = {32'd0, 32'($signed(mul_prod[31:0]) >>> 11)};
                  S_T1: m_in   = {32'd0, 32'($signed(mul_prod[31:0]) >>> 12)};
                  S_T2: begin
                     fine_in  = ft_w;
                     state_in = ST_OUT;
                  end
                  S_P0: m1_in = mul_prod;
                  S_P1: v2_in = mul_prod;
                  S_P2: v2_in = v2_ff + (mul_prod << 17) + (sx16(plo[63:48]) << 35);
                  S_P3: acc_in = 64'($signed(mul_prod) >>> 8);
                  S_P4: acc_in = acc_ff + (mul_prod << 12);
                  S_P5: begin
                     d_in = 64'($signed(mul_prod) >>> 33);
                     if (64'($signed(mul_prod) >>> 33) == 64'd0) begin
                        dz_in    = 1'b1;
                        state_in = ST_OUT;
                     end
                  end
                  S_P6: m1_in = mul_prod;
                  S_DIV: p_in = (m1_ff[63] != d_ff[63]) ? (64'd0 - div_q) : div_q;
                  S_P8: m_in = mul_prod;
                  S_P9: acc_in = 64'($signed(mul_prod) >>> 25);
                  S_P10: begin
                     v2_in    = 64'($signed(mul_prod) >>> 19);
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_in.result_kind       = cmd_ff;
               rsp_in.divide_by_zero    = dz_ff;
               rsp_in.temperature_centi = (cmd_ff == CMD_TEMP) ? cent : 32'd0;
               rsp_in.pressure_q24_8    = (cmd_ff == CMD_PRESS && !dz_ff) ?
                                          pres[31:0] : 32'd0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_T0;
         fine_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dz_ff        <= 1'b0;
         cmd_ff       <= CMD_TEMP;
         sel_ff       <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            tc_ff[i]  <= '0;
            plo_ff[i] <= '0;
            phi_ff[i] <= '0;
            p9_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fine_ff      <= fine_in;
         rsp_valid_ff <= rsp_valid_in;
         dz_ff        <= dz_in;
         cmd_ff       <= cmd_in;
         sel_ff       <= sel_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_S0_TEMP: tc_ff[0]  <= csr_wdata[47:0];
               REG_S0_PLO:  plo_ff[0] <= csr_wdata;
               REG_S0_PHI:  phi_ff[0] <= csr_wdata;
               REG_S0_P9:   p9_ff[0]  <= csr_wdata[15:0];
               REG_S1_TEMP: tc_ff[1]  <= csr_wdata[47:0];
               REG_S1_PLO:  plo_ff[1] <= csr_wdata;
               REG_S1_PHI:  phi_ff[1] <= csr_wdata;
               REG_S1_P9:   p9_ff[1]  <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      adc_ff <= adc_in;
      m1_ff  <= m1_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      v2_ff  <= v2_in;
      d_ff   <= d_in;
      p_ff   <= p_in;
      rsp_ff <= rsp_in;
   end

   bsc_mul #(.WIDTH(DATA_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   bsc_div #(.WIDTH(DATA_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (nmag),
      .denom    (dmag),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: bench/tb_baro_sensor_compensation_core.sv
// Testbench for the barometric compensation core: scoreboard with its own compensation model.
`timescale 1ns / 1ps
module tb_baro_sensor_compensation_core;
   import bsc_pkg::*;

   class comp_scoreboard;
      logic [63:0] coeffs [8];
      logic [31:0] fine_t;
      rsp_type     pending [$];
      int          errors;

      function new();
         for (int i = 0; i < 8; i++) coeffs[i] = '0;
         fine_t = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [3:0] idx, logic [63:0] val);
         if (idx == REG_S0_TEMP || idx == REG_S1_TEMP) coeffs[idx] = val & 64'hFFFF_FFFF_FFFF;
         else if (idx == REG_S0_P9 || idx == REG_S1_P9) coeffs[idx] = val & 64'hFFFF;
         else if (idx < 8) coeffs[idx] = val;
      endfunction

      function logic [63:0] s16(logic [63:0] w, int pos);
         logic [15:0] v;
         v = 16'(w >> pos);
         return {{48{v[15]}}, v};
      endfunction

      function logic signed [31:0] temp_centi(bit set, logic [19:0] adc);
         logic signed [31:0] t1, t2, t3, a, b, v1, v2, x;
         t1 = {16'd0, coeffs[set*4][15:0]};
         t2 = 32'($signed(coeffs[set*4][31:16]));
         t3 = 32'($signed(coeffs[set*4][47:32]));
         a = {12'd0, adc >> 3} - (t1 << 1);
         x = a * t2;
         v1 = x >>> 11;
         b = {12'd0, adc >> 4} - t1;
         x = b * b;
         x = x >>> 12;
         x = x * t3;
         v2 = x >>> 14;
         fine_t = v1 + v2;
         x = $signed(fine_t) * 5 + 128;
         return x >>> 8;
      endfunction

      function logic [31:0] press(bit set, logic [19:0] adc, output bit dz);
         logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, n, d, q, x;
         logic [63:0] nm, dm;
         p1 = {48'd0, coeffs[set*4+1][15:0]};
         p2 = s16(coeffs[set*4+1], 16); p3 = s16(coeffs[set*4+1], 32);
         p4 = s16(coeffs[set*4+1], 48); p5 = s16(coeffs[set*4+2], 0);
         p6 = s16(coeffs[set*4+2], 16); p7 = s16(coeffs[set*4+2], 32);
         p8 = s16(coeffs[set*4+2], 48); p9 = s16(coeffs[set*4+3], 0);
         v1 = {{32{fine_t[31]}}, fine_t} - 64'sd128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) << 17);
         v2 = v2 + (p4 << 35);
         x = v1 * v1 * p3;
         v1 = (x >>> 8) + ((v1 * p2) << 12);
         x = ((64'sd1 <<< 47) + v1) * p1;
         v1 = x >>> 33;
         dz = (v1 == 0);
         if (dz) return 32'd0;
         p = 64'sd1048576 - {44'd0, adc};
         n = ((p << 31) - v2) * 64'sd3125;
         d = v1;
         // magnitudes divided unsigned; most negative over minus one wraps
         nm = n[63] ? 64'(-n) : 64'(n);
         dm = d[63] ? 64'(-d) : 64'(d);
         q = $signed(nm / dm);
         p = (n[63] != d[63]) ? -q : q;
         x = p9 * (p >>> 13) * (p >>> 13);
         v1 = x >>> 25;
         x = p8 * p;
         v2 = x >>> 19;
         x = p + v1 + v2;
         p = (x >>> 8) + (p7 << 4);
         return p[31:0];
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         bit dz;
         e = '0;
         e.result_kind = r.command;
         if (r.command == CMD_TEMP) e.temperature_centi = temp_centi(r.sensor_select, r.raw_reading);
         else begin
            e.pressure_q24_8 = press(r.sensor_select, r.raw_reading, dz);
            e.divide_by_zero = dz;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind); errors++;
         end
         if (a.temperature_centi !== e.temperature_centi) begin
            $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                   a.temperature_centi); errors++;
         end
         if (a.pressure_q24_8 !== e.pressure_q24_8) begin
            $error("pressure_q24_8 exp %0d got %0d", e.pressure_q24_8, a.pressure_q24_8);
            errors++;
         end
         if (a.divide_by_zero !== e.divide_by_zero) begin
            $error("divide_by_zero exp %0d got %0d", e.divide_by_zero, a.divide_by_zero);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_write_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   comp_scoreboard sb = new();
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;
   int quiet = 0;
   localparam int QUIET_LIMIT = 200000;

   baro_sensor_compensation_core DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

   // valid stays high after acceptance until the next word or an idle cycle replaces it
   task automatic send_word(req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [63:0] val);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type rand_word();
      req_type r;
      r.command = 1'($urandom_range(1));
      r.sensor_select = 1'($urandom_range(1));
      r.raw_reading = 20'($urandom);
      return r;
   endfunction

   task automatic load_set(int mode);
      for (int i = 0; i < 8; i++) begin
         logic [63:0] v;
         case (mode)
            0: v = '0;
            1: v = '1;
            2: v = {$urandom, $urandom};
            default: begin
               // realistic-looking calibration values with random spread
               case (i % 4)
                  0: v = {16'd0, 16'(-500 + $urandom_range(1000)),
                          16'(26000 + $urandom_range(2000)),
                          16'(27000 + $urandom_range(2000))};
                  1: v = {16'(2000 + $urandom_range(2000)), 16'(-100 + $urandom_range(5000)),
                          16'(-10800 + $urandom_range(200)), 16'(36000 + $urandom_range(2000))};
                  2: v = {16'(-12000 + $urandom_range(400)), 16'(15000 + $urandom_range(500)),
                          16'(-100 + $urandom_range(10)), 16'($urandom_range(300))};
                  default: v = 64'(6000 + $urandom_range(100));
               endcase
            end
         endcase
         write_csr(4'(i), v);
      end
      write_csr(4'd9, '1); // ignored index
      csr_write_en <= 0;
   endtask

   initial begin
      req_type r;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // pressure before any temperature, all-zero coefficients
      r = '0; r.command = CMD_PRESS; send_word(r);
      r.command = CMD_TEMP; r.raw_reading = '1; send_word(r);
      drain();
      load_set(1);
      for (int i = 0; i < 4; i++) begin
         r.command = i[0]; r.sensor_select = i[1]; r.raw_reading = i[0] ? '1 : '0; send_word(r);
         r.raw_reading = ~r.raw_reading; send_word(r);
      end
      drain();
      load_set(3);
      for (int i = 0; i < 8; i++) begin
         r.command = i[0]; r.sensor_select = i[1];
         r.raw_reading = i[2] ? 20'd415148 : 20'd519888; send_word(r);
      end
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 13 : (ph == 1 ? 76 : 0);
         recv_idle = (ph == 0) ? 76 : (ph == 1 ? 13 : 0);
         for (int blk = 0; blk < 6; blk++) begin
            load_set(blk < 4 ? 3 : blk - 4 + 1);
            if (blk == 5) load_set(2);
            if (ph == 2 && blk == 0) fork
               begin hold_off = 1; repeat (3000) @(posedge clock); hold_off = 0; end
            join_none
            for (int k = 0; k < 52; k++) begin
               r = rand_word();
               // odd-numbered words are mostly pressure words; every word picks its set at random
               if (k % 2 == 1 && $urandom_range(9) < 8) begin
                  r.command = CMD_PRESS;
               end
               send_word(r);
            end
            drain();
         end
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
